// ===== rtl/rcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared widths and item types for the rectangle/circle clearance check.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int COORD_BITS = 32;
  localparam int UNS_BITS   = COORD_BITS - 1;
  localparam int EXT_BITS   = COORD_BITS + 1;      // corner plus extent
  localparam int MAG_BITS   = COORD_BITS + 1;      // magnitude of a coordinate gap
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int DIST_BITS  = SQ_BITS + 1;         // sum of two squares
  localparam int SUM_BITS   = COORD_BITS;          // clearance plus radius
  localparam int LIM_BITS   = 2 * SUM_BITS;
  localparam int ROOT_BITS  = (DIST_BITS + 1) / 2;
  localparam int RAD_BITS   = 2 * ROOT_BITS;
  localparam int REM_BITS   = ROOT_BITS + 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rect_x;
    logic signed [COORD_BITS-1:0] rect_y;
    logic        [UNS_BITS-1:0]   rect_width;
    logic        [UNS_BITS-1:0]   rect_height;
    logic signed [COORD_BITS-1:0] circle_x;
    logic signed [COORD_BITS-1:0] circle_y;
    logic        [UNS_BITS-1:0]   radius;
    logic        [UNS_BITS-1:0]   clearance;
  } in_t;

  typedef struct packed {
    logic                         collides;
    logic                         centre_inside;
    logic        [UNS_BITS-1:0]   actual_distance;
    logic signed [COORD_BITS-1:0] nearest_x;
    logic signed [COORD_BITS-1:0] nearest_y;
  } out_t;

  // Per-item fields that ride alongside the root extraction
  typedef struct packed {
    logic                         collides;
    logic                         centre_inside;
    logic signed [COORD_BITS-1:0] nearest_x;
    logic signed [COORD_BITS-1:0] nearest_y;
    logic        [UNS_BITS-1:0]   radius;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [DIST_BITS-1:0] sq_dist;
  } geom_t;

  typedef struct packed {
    side_t                side;
    logic [ROOT_BITS-1:0] root;
  } root_t;

endpackage

// ===== rtl/rcc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_in_if
// Valid/ready channel carrying one rectangle/circle query item.
// ----------------------------------------------------------------------------
interface rcc_in_if;
  logic         valid;
  logic         ready;
  rcc_pkg::in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rcc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_out_if
// Valid/ready channel carrying one clearance result item.
// ----------------------------------------------------------------------------
interface rcc_out_if;
  logic          valid;
  logic          ready;
  rcc_pkg::out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rcc_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_geom
// Six-stage front end: edges, clamps, squares, side distances, nearest side.
// ----------------------------------------------------------------------------
module rcc_geom (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcc_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcc_pkg::geom_t      out_data
);

  localparam int EB = rcc_pkg::EXT_BITS;
  localparam int MB = rcc_pkg::MAG_BITS;
  localparam int SB = rcc_pkg::SQ_BITS;
  localparam int DB = rcc_pkg::DIST_BITS;
  localparam int CB = rcc_pkg::COORD_BITS;
  localparam int UB = rcc_pkg::UNS_BITS;

  function automatic logic signed [EB-1:0] clamp_c(input logic signed [EB-1:0] v,
                                                   input logic signed [EB-1:0] lo,
                                                   input logic signed [EB-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [MB-1:0] abs_gap(input logic signed [EB-1:0] a,
                                            input logic signed [EB-1:0] b);
    logic signed [EB:0] d;
    d = (EB+1)'(a) - (EB+1)'(b);
    if (d < 0) d = -d;
    return d[MB-1:0];
  endfunction

  function automatic logic signed [CB-1:0] sat_c(input logic signed [EB-1:0] v);
    logic signed [EB-1:0] cmax;
    logic signed [EB-1:0] cmin;
    cmax = EB'({1'b0, {(CB-1){1'b1}}});
    cmin = -cmax - EB'(1);
    if (v > cmax) return cmax[CB-1:0];
    if (v < cmin) return cmin[CB-1:0];
    return v[CB-1:0];
  endfunction

  logic [5:0] vld;
  logic [6:0] adv;

  always_comb begin
    adv[6] = out_ready;
    for (int k = 5; k >= 0; k--) adv[k] = !vld[k] || adv[k+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[5];

  // stage A
  logic signed [EB-1:0] ax0, ax1, ay0, ay1, acx, acy;
  logic [UB-1:0] ar;
  logic [rcc_pkg::SUM_BITS-1:0] as_sum;
  // stage B
  logic signed [EB-1:0] bx0, bx1, bxc, by0, by1, byc;
  logic [MB-1:0] bdx0, bdx1, bdxc, bdy0, bdy1, bdyc;
  logic binside;
  logic [UB-1:0] br;
  logic [rcc_pkg::SUM_BITS-1:0] bs;
  // stage C
  logic signed [EB-1:0] cx0, cx1, cxc, cy0, cy1, cyc;
  logic [SB-1:0] sx0, sx1, sxc, sy0, sy1, syc;
  logic [rcc_pkg::LIM_BITS-1:0] clim;
  logic cinside;
  logic [UB-1:0] cr;
  // stage D
  logic signed [EB-1:0] dx0, dx1, dxc, dy0, dy1, dyc;
  logic [DB-1:0] d0, d1, d2, d3;
  logic [rcc_pkg::LIM_BITS-1:0] dlim;
  logic dinside;
  logic [UB-1:0] dr;
  // stage E
  logic [DB-1:0] e01, e23;
  logic signed [EB-1:0] enx01, eny01, enx23, eny23;
  logic [rcc_pkg::LIM_BITS-1:0] elim;
  logic einside;
  logic [UB-1:0] er;

  logic signed [EB-1:0] xc_c, yc_c;
  logic pick01, pick23, pickf;
  logic [DB-1:0] fdist;

  always_comb begin
    xc_c   = clamp_c(acx, ax0, ax1);
    yc_c   = clamp_c(acy, ay0, ay1);
    pick01 = d1 < d0;
    pick23 = d3 < d2;
    pickf  = e23 < e01;
    fdist  = pickf ? e23 : e01;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < 6; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ax0    <= EB'(in_data.rect_x);
      ay0    <= EB'(in_data.rect_y);
      ax1    <= EB'(in_data.rect_x) + $signed({2'b00, in_data.rect_width});
      ay1    <= EB'(in_data.rect_y) + $signed({2'b00, in_data.rect_height});
      acx    <= EB'(in_data.circle_x);
      acy    <= EB'(in_data.circle_y);
      ar     <= in_data.radius;
      as_sum <= rcc_pkg::SUM_BITS'(in_data.clearance) + rcc_pkg::SUM_BITS'(in_data.radius);
    end
    if (adv[1]) begin
      bx0 <= ax0;  bx1 <= ax1;  bxc <= xc_c;
      by0 <= ay0;  by1 <= ay1;  byc <= yc_c;
      bdx0 <= abs_gap(ax0, acx);
      bdx1 <= abs_gap(ax1, acx);
      bdxc <= abs_gap(xc_c, acx);
      bdy0 <= abs_gap(ay0, acy);
      bdy1 <= abs_gap(ay1, acy);
      bdyc <= abs_gap(yc_c, acy);
      binside <= (acx >= ax0) && (acx <= ax1) && (acy >= ay0) && (acy <= ay1);
      br <= ar;
      bs <= as_sum;
    end
    if (adv[2]) begin
      cx0 <= bx0;  cx1 <= bx1;  cxc <= bxc;
      cy0 <= by0;  cy1 <= by1;  cyc <= byc;
      sx0 <= SB'(bdx0) * SB'(bdx0);
      sx1 <= SB'(bdx1) * SB'(bdx1);
      sxc <= SB'(bdxc) * SB'(bdxc);
      sy0 <= SB'(bdy0) * SB'(bdy0);
      sy1 <= SB'(bdy1) * SB'(bdy1);
      syc <= SB'(bdyc) * SB'(bdyc);
      clim <= rcc_pkg::LIM_BITS'(bs) * rcc_pkg::LIM_BITS'(bs);
      cinside <= binside;
      cr <= br;
    end
    if (adv[3]) begin
      dx0 <= cx0;  dx1 <= cx1;  dxc <= cxc;
      dy0 <= cy0;  dy1 <= cy1;  dyc <= cyc;
      // sides in order left, top, right, bottom
      d0 <= DB'(sx0) + DB'(syc);
      d1 <= DB'(sxc) + DB'(sy1);
      d2 <= DB'(sx1) + DB'(syc);
      d3 <= DB'(sxc) + DB'(sy0);
      dlim <= clim;
      dinside <= cinside;
      dr <= cr;
    end
    if (adv[4]) begin
      e01   <= pick01 ? d1 : d0;
      enx01 <= pick01 ? dxc : dx0;
      eny01 <= pick01 ? dy1 : dyc;
      e23   <= pick23 ? d3 : d2;
      enx23 <= pick23 ? dxc : dx1;
      eny23 <= pick23 ? dy0 : dyc;
      elim <= dlim;
      einside <= dinside;
      er <= dr;
    end
    if (adv[5]) begin
      out_data.sq_dist <= fdist;
      out_data.side.nearest_x <= sat_c(pickf ? enx23 : enx01);
      out_data.side.nearest_y <= sat_c(pickf ? eny23 : eny01);
      out_data.side.centre_inside <= einside;
      out_data.side.collides <= einside || (fdist == '0) || (fdist < DB'(elim));
      out_data.side.radius <= er;
    end
  end

endmodule

// ===== rtl/rcc_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_isqrt
// Pipelined floor square root, one root bit per stage, side fields carried.
// ----------------------------------------------------------------------------
module rcc_isqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rcc_pkg::geom_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rcc_pkg::root_t  out_data
);

  localparam int NS = rcc_pkg::ROOT_BITS;
  localparam int RB = rcc_pkg::RAD_BITS;
  localparam int MB = rcc_pkg::REM_BITS;

  logic [NS-1:0] vld;
  logic [NS:0]   adv;

  logic [RB-1:0]    rad  [NS];
  logic [MB-1:0]    rem  [NS];
  logic [NS-1:0]    root [NS];
  rcc_pkg::side_t   side [NS];

  assign adv[NS]   = out_ready;
  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];
  assign out_data.root = root[NS-1];
  assign out_data.side = side[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RB-1:0]  rad_in;
    logic [MB-1:0]  rem_in, rem_sh, trial;
    logic [NS-1:0]  root_in;
    rcc_pkg::side_t side_in;
    logic           vld_in, ge;

    if (k == 0) begin : g_first
      assign rad_in  = RB'(in_data.sq_dist);
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_data.side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rad_in  = rad[k-1];
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
      assign side_in = side[k-1];
      assign vld_in  = vld[k-1];
    end

    assign adv[k] = !vld[k] || adv[k+1];
    assign rem_sh = {rem_in[MB-3:0], rad_in[RB-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rad[k]  <= {rad_in[RB-3:0], 2'b00};
        rem[k]  <= ge ? rem_sh - trial : rem_sh;
        root[k] <= {root_in[NS-2:0], ge};
        side[k] <= side_in;
      end
    end
  end

endmodule

// ===== rtl/rect_circle_clearance_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_circle_clearance_check
// Clearance test between an axis-aligned rectangle and a circle.
// ----------------------------------------------------------------------------
//  channel | role   | carries
//  --------+--------+-------------------------------------------------------
//  req     | sink   | rectangle corner/extent, circle centre/radius, clearance
//  rsp     | source | collides, centre_inside, actual_distance, nearest point
//
//  One item enters per cycle while nothing stalls; each result reaches rsp
//  through 41 register stages: 6 geometry, 34 root, 1 output.
//  The depth is set by the bit-per-stage square root of the nearest distance.
//  Synchronous active-high rst empties every stage; no clearing pass.
//  Each stage holds only while full and blocked downstream, so bubbles
//  squeeze out and new items enter while rsp stalls, until all stages fill.
// ----------------------------------------------------------------------------
module rect_circle_clearance_check (
  input  logic      clk,
  input  logic      rst,
  rcc_in_if.sink    req,
  rcc_out_if.source rsp
);

  localparam int UB = rcc_pkg::UNS_BITS;
  localparam int RB = rcc_pkg::ROOT_BITS;

  // geometry front end -> root pipeline
  logic           g_valid, g_ready;
  rcc_pkg::geom_t g_data;
  // root pipeline -> output stage
  logic           r_valid, r_ready;
  rcc_pkg::root_t r_data;

  rcc_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_data   (req.payload),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_data  (g_data)
  );

  rcc_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_data   (g_data),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_data  (r_data)
  );

  // Output stage: distance beyond the radius, clamped at zero and saturated
  logic          o_valid;
  rcc_pkg::out_t o_data;
  logic signed [RB:0] gap;
  logic [UB-1:0] act;

  always_comb begin
    gap = $signed({1'b0, r_data.root}) - $signed((RB+1)'(r_data.side.radius));
    if (gap <= 0) begin
      act = '0;
    end else if (gap > $signed((RB+1)'({UB{1'b1}}))) begin
      act = {UB{1'b1}};
    end else begin
      act = gap[UB-1:0];
    end
  end

  // Take a new result whenever the output register is empty or being drained
  assign r_ready = !o_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (r_ready) begin
      o_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_ready) begin
      o_data.collides        <= r_data.side.collides;
      o_data.centre_inside   <= r_data.side.centre_inside;
      o_data.actual_distance <= act;
      o_data.nearest_x       <= r_data.side.nearest_x;
      o_data.nearest_y       <= r_data.side.nearest_y;
    end
  end

  assign rsp.valid   = o_valid;
  assign rsp.payload = o_data;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rectangle/circle clearance check. A table of
// directed queries runs first, then random queries; every result is checked
// field by field, in arrival order, against a typed-in result or a geometry predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY     = 41;
  localparam int N_RANDOM    = 430;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rcc_in_if  req ();
  rcc_out_if rsp ();

  rect_circle_clearance_check i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed query with an optional hand-written result
  typedef struct {
    rcc_pkg::in_t  q;
    logic          known;
    rcc_pkg::out_t r;
  } query_row_t;

  rcc_pkg::out_t expected_results[$];
  query_row_t    query_table[$];
  bit            failed = 1'b0;
  bit            stim_done = 1'b0;
  int unsigned   cycle_count = 0;
  int unsigned   hold_off = 0;   // long receiver hold-off, counted in cycles
  bit            calm = 1'b0;    // stretch with no idling on either side

  // --------------------------------------------------------------------------
  // Predictor: full-precision clamp of the centre onto each side, in the
  // order left, top, right, bottom; the first strict minimum wins.
  // --------------------------------------------------------------------------
  function automatic longint clampl(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [127:0] gap_sq(longint px, longint py, longint cx, longint cy);
    logic [127:0] dx, dy;
    longint ax, ay;
    ax = px - cx;
    ay = py - cy;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    dx = 128'(ax);
    dy = 128'(ay);
    return dx * dx + dy * dy;
  endfunction

  function automatic rcc_pkg::out_t predict_clearance(rcc_pkg::in_t q);
    longint x0, y0, x1, y1, cx, cy, rad, clr, act, nx, ny;
    longint px[4], py[4];
    logic [127:0] best, d, lim, root, cand;
    bit centre_in;
    rcc_pkg::out_t r;
    x0 = longint'(q.rect_x);
    y0 = longint'(q.rect_y);
    x1 = x0 + longint'({1'b0, q.rect_width});
    y1 = y0 + longint'({1'b0, q.rect_height});
    cx = longint'(q.circle_x);
    cy = longint'(q.circle_y);
    rad = longint'({1'b0, q.radius});
    clr = longint'({1'b0, q.clearance});
    px[0] = x0;                  py[0] = clampl(cy, y0, y1);
    px[1] = clampl(cx, x0, x1);  py[1] = y1;
    px[2] = x1;                  py[2] = clampl(cy, y0, y1);
    px[3] = clampl(cx, x0, x1);  py[3] = y0;
    nx = px[0];
    ny = py[0];
    best = gap_sq(px[0], py[0], cx, cy);
    for (int i = 1; i < 4; i++) begin
      d = gap_sq(px[i], py[i], cx, cy);
      if (d < best) begin
        best = d;
        nx = px[i];
        ny = py[i];
      end
    end
    centre_in = cx >= x0 && cx <= x1 && cy >= y0 && cy <= y1;
    lim = 128'(clr + rad) * 128'(clr + rad);
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      cand = root | (128'(1) << b);
      if (!(best < cand * cand)) root = cand;
    end
    act = longint'(root[63:0]) - rad;
    r.collides        = centre_in || best == 0 || best < lim;
    r.centre_inside   = centre_in;
    r.actual_distance = 31'(clampl(act, 0, 64'h7FFF_FFFF));
    r.nearest_x       = 32'(clampl(nx, -64'sd2147483648, 64'sd2147483647));
    r.nearest_y       = 32'(clampl(ny, -64'sd2147483648, 64'sd2147483647));
    return r;
  endfunction

  function automatic rcc_pkg::in_t make_query(int rx, int ry, int w, int h, int cx,
                                              int cy, int rad, int clr);
    rcc_pkg::in_t q;
    q.rect_x = rx;  q.rect_y = ry;
    q.rect_width = 31'(w);  q.rect_height = 31'(h);
    q.circle_x = cx;  q.circle_y = cy;
    q.radius = 31'(rad);  q.clearance = 31'(clr);
    return q;
  endfunction

  function automatic rcc_pkg::out_t make_result(int col, int ins, int act_dist, int nx,
                                                int ny);
    rcc_pkg::out_t r;
    r.collides = 1'(col);  r.centre_inside = 1'(ins);
    r.actual_distance = 31'(act_dist);  r.nearest_x = nx;  r.nearest_y = ny;
    return r;
  endfunction

  task automatic add_row(rcc_pkg::in_t q, bit known = 1'b0, rcc_pkg::out_t r = '0);
    query_row_t row;
    row.q = q;  row.known = known;  row.r = r;
    query_table.insert(query_table.size(), row);
  endtask

  // Random query; most sit near a small rectangle so every side and the
  // inside case come up, the rest use raw full-range fields.
  function automatic rcc_pkg::in_t random_query();
    rcc_pkg::in_t q;
    int base_x, base_y;
    if ($urandom_range(0, 3) == 0) begin
      q = $bits(rcc_pkg::in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom});
    end else begin
      base_x = $urandom_range(0, 2000) - 1000;
      base_y = $urandom_range(0, 2000) - 1000;
      q.rect_x      = base_x;
      q.rect_y      = base_y;
      q.rect_width  = 31'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 200));
      q.rect_height = 31'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 200));
      q.circle_x    = base_x + $urandom_range(0, 600) - 200;
      q.circle_y    = base_y + $urandom_range(0, 600) - 200;
      q.radius      = 31'($urandom_range(0, 150));
      q.clearance   = 31'($urandom_range(0, 100));
    end
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer each item, idle at random, hold valid high across
  // back-to-back items.
  // --------------------------------------------------------------------------
  task automatic send_query(rcc_pkg::in_t q);
    while (!calm && $urandom_range(0, 99) < 35) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.payload <= q;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  initial begin
    rcc_pkg::out_t r;
    req.valid   = 1'b0;
    req.payload = '0;
    // Extremes, every side winning, degenerate shapes and saturation
    add_row(make_query(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, make_result(1, 1, 0, 0, 0));
    add_row(make_query(0, 0, 10, 10, 5, 5, 0, 0), 1'b1, make_result(1, 1, 5, 0, 5));
    add_row(make_query(0, 0, 10, 10, -20, 5, 0, 0), 1'b1, make_result(0, 0, 20, 0, 5));
    add_row(make_query(0, 0, 10, 10, 5, 30, 0, 0), 1'b1, make_result(0, 0, 20, 5, 10));
    add_row(make_query(0, 0, 10, 10, 25, 5, 3, 0), 1'b1, make_result(0, 0, 12, 10, 5));
    add_row(make_query(0, 0, 10, 10, 5, -7, 2, 10), 1'b1, make_result(1, 0, 5, 5, 0));
    add_row(make_query(0, 0, 10, 10, 13, 14, 5, 0), 1'b1, make_result(0, 0, 0, 10, 10));
    add_row(make_query(0, 0, 10, 10, 10, 10, 0, 0), 1'b1, make_result(1, 1, 0, 10, 10));
    add_row(make_query(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    add_row(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 0, 0));
    add_row(make_query(32'h8000_0000, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 0, 0), 1'b1,
            make_result(0, 0, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    add_row(make_query(32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 5, 32'h7FFF_FFFF, 2, 0, 0));
    add_row(make_query(0, 32'h7FFF_FFF0, 4, 31'h7FFF_FFFF, 2, 32'h8000_0000, 1, 1));
    add_row(make_query(0, 0, 0, 20, 7, 10, 0, 0));
    add_row(make_query(0, 0, 20, 0, 10, -4, 0, 4));
    add_row(make_query(0, 0, 0, 0, 3, 4, 5, 0));
    add_row(make_query(-50, -50, 100, 100, -40, 0, 10, 1));
    add_row(make_query(0, 0, 10, 10, 20, 20, 0, 31'h7FFF_FFFF));
    add_row(make_query(32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555,
                       32'hAAAA_AAAA, 32'h5555_5555, 31'h5555_5555, 31'h2AAA_AAAA));
    add_row(make_query(-3, -3, 6, 6, 0, 0, 31'h7FFF_FFFF, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the table; typed-in rows must also agree with the predictor
    foreach (query_table[i]) begin
      r = predict_clearance(query_table[i].q);
      if (query_table[i].known && r !== query_table[i].r) begin
        $display("%0t: table row %0d expected %h predictor %h", $time, i,
                 query_table[i].r, r);
        failed = 1'b1;
      end
      expected_results.insert(expected_results.size(),
                              query_table[i].known ? query_table[i].r : r);
      send_query(query_table[i].q);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      rcc_pkg::in_t q;
      calm = (n >= 150 && n < 220);   // back-to-back stretch
      q = random_query();
      expected_results.insert(expected_results.size(), predict_clearance(q));
      send_query(q);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Receiver: idle at random; once, hold off long enough to fill the
  // pipeline and stall the sender.
  // --------------------------------------------------------------------------
  initial begin
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (cycle_count == 400) hold_off = 200;
      if (hold_off != 0) begin
        hold_off--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm || $urandom_range(0, 99) >= 35;
      end
    end
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk) begin
    rcc_pkg::out_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp.payload);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (rsp.payload.collides !== want.collides)
          $display("%0t: collides expected %b actual %b", $time, want.collides,
                   rsp.payload.collides);
        if (rsp.payload.centre_inside !== want.centre_inside)
          $display("%0t: centre_inside expected %b actual %b", $time,
                   want.centre_inside, rsp.payload.centre_inside);
        if (rsp.payload.actual_distance !== want.actual_distance)
          $display("%0t: actual_distance expected %0d actual %0d", $time,
                   want.actual_distance, rsp.payload.actual_distance);
        if (rsp.payload.nearest_x !== want.nearest_x)
          $display("%0t: nearest_x expected %0d actual %0d", $time, want.nearest_x,
                   rsp.payload.nearest_x);
        if (rsp.payload.nearest_y !== want.nearest_y)
          $display("%0t: nearest_y expected %0d actual %0d", $time, want.nearest_y,
                   rsp.payload.nearest_y);
        if (rsp.payload !== want) failed = 1'b1;
      end
    end
  end

  // Advance the cycle counter; drop out on timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drain, then let the pipeline settle before the verdict
  initial begin
    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== rect_circle_clearance_check.f =====
rtl/rcc_pkg.sv
rtl/rcc_in_if.sv
rtl/rcc_out_if.sv
rtl/rcc_geom.sv
rtl/rcc_isqrt.sv
rtl/rect_circle_clearance_check.sv
tb/tb_top.sv
